// File: design/bnephp_pkg.sv
// shared types and constants for the bnep header parser
`timescale 1ns / 1ps

package bnephp_pkg;

  // field tags, also used as parser states
  typedef enum logic [4:0] {
    FIELD_TYPE       = 5'd0,
    FIELD_DST_MAC    = 5'd1,
    FIELD_SRC_MAC    = 5'd2,
    FIELD_ETHERTYPE  = 5'd3,
    FIELD_CTRL_TYPE  = 5'd4,
    FIELD_UNK_CTRL   = 5'd5,
    FIELD_UUID_SIZE  = 5'd6,
    FIELD_DST_UUID   = 5'd7,
    FIELD_SRC_UUID   = 5'd8,
    FIELD_RESPONSE   = 5'd9,
    FIELD_LIST_LEN   = 5'd10,
    FIELD_RANGE_LO   = 5'd11,
    FIELD_RANGE_HI   = 5'd12,
    FIELD_MCAST_LO   = 5'd13,
    FIELD_MCAST_HI   = 5'd14,
    FIELD_EXT_HDR    = 5'd15,
    FIELD_EXT_LEN    = 5'd16,
    FIELD_EXT_SKIP   = 5'd17,
    FIELD_PAYLOAD    = 5'd18
  } field_t;

  // bnep packet kinds
  localparam logic [6:0] KIND_GENERAL  = 7'h00;
  localparam logic [6:0] KIND_CONTROL  = 7'h01;
  localparam logic [6:0] KIND_SRC_ONLY = 7'h03;
  localparam logic [6:0] KIND_DST_ONLY = 7'h04;

  // control message types
  localparam logic [7:0] CTRL_NOT_UNDERSTOOD = 8'h00;
  localparam logic [7:0] CTRL_SETUP_REQ      = 8'h01;
  localparam logic [7:0] CTRL_SETUP_RSP      = 8'h02;
  localparam logic [7:0] CTRL_FILTER_NET_SET = 8'h03;
  localparam logic [7:0] CTRL_FILTER_NET_RSP = 8'h04;
  localparam logic [7:0] CTRL_FILTER_MC_SET  = 8'h05;
  localparam logic [7:0] CTRL_FILTER_MC_RSP  = 8'h06;

  localparam int unsigned EXT_BIT      = 7;
  localparam logic [6:0]  EXT_CONTROL  = 7'h00;
  localparam logic [15:0] MAC_LAST     = 16'd5;
  localparam logic [15:0] RANGE_PAIR   = 16'd4;
  localparam logic [15:0] MCAST_PAIR   = 16'd12;
  localparam logic [15:0] POS_MAX      = 16'hFFFF;

  typedef struct packed {
    field_t      parse_state;
    logic [15:0] field_position;
    logic [15:0] value_accumulator;
    logic [15:0] list_bytes_left;
    logic [7:0]  uuid_width;
    logic [6:0]  saved_kind;
    logic        extension_pending;
    logic        in_extension;
    logic [15:0] saved_ether_type;
    logic        source_group_flag;
    logic        top_extension;
    logic        list_long;
    logic        ext_control;
  } parse_ctx_t;

  localparam parse_ctx_t CTX_RESET = '{parse_state: FIELD_TYPE, default: '0};

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [4:0]  field_code;
    logic [15:0] byte_in_field;
    logic [15:0] field_value;
    logic [6:0]  packet_kind;
    logic        has_extension;
    logic [15:0] ether_type;
    logic        group_source_warning;
    logic        header_truncated;
    logic        last_byte;
  } tag_result_t;

endpackage

// File: design/bnephp_step.sv
// per-byte parse step: next parser context and the tagged result
`timescale 1ns / 1ps

module bnephp_step (
  input  bnephp_pkg::parse_ctx_t  ctx,
  input  logic [7:0]              packet_byte,
  input  logic                    end_of_packet,
  output bnephp_pkg::parse_ctx_t  ctx_next,
  output bnephp_pkg::tag_result_t result
);

  bnephp_pkg::parse_ctx_t n;
  bnephp_pkg::field_t     cur;
  bnephp_pkg::field_t     nxt;
  bnephp_pkg::field_t     after_msg;
  logic                   done;
  logic [15:0]            val;
  logic [15:0]            range_left;
  logic [15:0]            mcast_left;
  logic [15:0]            skip_left;
  logic [16:0]            pos_plus;
  logic [6:0]             kind;

  assign val = (ctx.field_position == 16'd0) ? {8'd0, packet_byte}
                                             : {ctx.value_accumulator[7:0], packet_byte};
  assign after_msg = ctx.extension_pending ? bnephp_pkg::FIELD_EXT_HDR
                                           : bnephp_pkg::FIELD_PAYLOAD;
  assign range_left = (ctx.list_bytes_left > bnephp_pkg::RANGE_PAIR)
                      ? ctx.list_bytes_left - bnephp_pkg::RANGE_PAIR : 16'd0;
  assign mcast_left = (ctx.list_bytes_left > bnephp_pkg::MCAST_PAIR)
                      ? ctx.list_bytes_left - bnephp_pkg::MCAST_PAIR : 16'd0;
  assign skip_left  = (ctx.list_bytes_left != 16'd0) ? ctx.list_bytes_left - 16'd1 : 16'd0;
  assign pos_plus   = {1'b0, ctx.field_position} + 17'd1;
  assign kind       = packet_byte[6:0];

  always_comb begin
    n    = ctx;
    cur  = ctx.parse_state;
    nxt  = ctx.parse_state;
    done = 1'b0;
    unique case (ctx.parse_state)
      bnephp_pkg::FIELD_TYPE: begin
        n.saved_kind        = kind;
        n.top_extension     = packet_byte[bnephp_pkg::EXT_BIT];
        n.extension_pending = packet_byte[bnephp_pkg::EXT_BIT];
        n.saved_ether_type  = 16'd0;
        n.source_group_flag = 1'b0;
        done = 1'b1;
        if (kind == bnephp_pkg::KIND_GENERAL || kind == bnephp_pkg::KIND_DST_ONLY) begin
          nxt = bnephp_pkg::FIELD_DST_MAC;
        end else if (kind == bnephp_pkg::KIND_SRC_ONLY) begin
          nxt = bnephp_pkg::FIELD_SRC_MAC;
        end else if (kind == bnephp_pkg::KIND_CONTROL) begin
          nxt = bnephp_pkg::FIELD_CTRL_TYPE;
        end else begin
          nxt = bnephp_pkg::FIELD_ETHERTYPE;
        end
      end
      bnephp_pkg::FIELD_DST_MAC: begin
        if (ctx.field_position >= bnephp_pkg::MAC_LAST) begin
          done = 1'b1;
          nxt  = (ctx.saved_kind == bnephp_pkg::KIND_GENERAL) ? bnephp_pkg::FIELD_SRC_MAC
                                                              : bnephp_pkg::FIELD_ETHERTYPE;
        end
      end
      bnephp_pkg::FIELD_SRC_MAC: begin
        if (ctx.field_position == 16'd0 && packet_byte[0]) begin
          n.source_group_flag = 1'b1;
        end
        if (ctx.field_position >= bnephp_pkg::MAC_LAST) begin
          done = 1'b1;
          nxt  = bnephp_pkg::FIELD_ETHERTYPE;
        end
      end
      bnephp_pkg::FIELD_ETHERTYPE: begin
        if (ctx.field_position >= 16'd1) begin
          n.saved_ether_type = val;
          done = 1'b1;
          nxt  = after_msg;
        end
      end
      bnephp_pkg::FIELD_CTRL_TYPE: begin
        done = 1'b1;
        case (packet_byte)
          bnephp_pkg::CTRL_NOT_UNDERSTOOD: nxt = bnephp_pkg::FIELD_UNK_CTRL;
          bnephp_pkg::CTRL_SETUP_REQ:      nxt = bnephp_pkg::FIELD_UUID_SIZE;
          bnephp_pkg::CTRL_SETUP_RSP,
          bnephp_pkg::CTRL_FILTER_NET_RSP,
          bnephp_pkg::CTRL_FILTER_MC_RSP:  nxt = bnephp_pkg::FIELD_RESPONSE;
          bnephp_pkg::CTRL_FILTER_NET_SET,
          bnephp_pkg::CTRL_FILTER_MC_SET: begin
            n.list_long = (packet_byte == bnephp_pkg::CTRL_FILTER_MC_SET);
            nxt = bnephp_pkg::FIELD_LIST_LEN;
          end
          default: nxt = after_msg;
        endcase
      end
      bnephp_pkg::FIELD_UNK_CTRL: begin
        done = 1'b1;
        nxt  = after_msg;
      end
      bnephp_pkg::FIELD_UUID_SIZE: begin
        n.uuid_width = packet_byte;
        done = 1'b1;
        nxt  = (packet_byte == 8'd0) ? after_msg : bnephp_pkg::FIELD_DST_UUID;
      end
      bnephp_pkg::FIELD_DST_UUID: begin
        if (pos_plus >= {9'd0, ctx.uuid_width}) begin
          done = 1'b1;
          nxt  = bnephp_pkg::FIELD_SRC_UUID;
        end
      end
      bnephp_pkg::FIELD_SRC_UUID: begin
        if (pos_plus >= {9'd0, ctx.uuid_width}) begin
          done = 1'b1;
          nxt  = after_msg;
        end
      end
      bnephp_pkg::FIELD_RESPONSE: begin
        if (ctx.field_position >= 16'd1) begin
          done = 1'b1;
          nxt  = after_msg;
        end
      end
      bnephp_pkg::FIELD_LIST_LEN: begin
        if (ctx.field_position >= 16'd1) begin
          n.list_bytes_left = val;
          done = 1'b1;
          if (val == 16'd0) begin
            nxt = after_msg;
          end else begin
            nxt = ctx.list_long ? bnephp_pkg::FIELD_MCAST_LO : bnephp_pkg::FIELD_RANGE_LO;
          end
        end
      end
      bnephp_pkg::FIELD_RANGE_LO: begin
        if (ctx.field_position >= 16'd1) begin
          done = 1'b1;
          nxt  = bnephp_pkg::FIELD_RANGE_HI;
        end
      end
      bnephp_pkg::FIELD_RANGE_HI: begin
        if (ctx.field_position >= 16'd1) begin
          n.list_bytes_left = range_left;
          done = 1'b1;
          nxt  = (range_left != 16'd0) ? bnephp_pkg::FIELD_RANGE_LO : after_msg;
        end
      end
      bnephp_pkg::FIELD_MCAST_LO: begin
        if (ctx.field_position >= bnephp_pkg::MAC_LAST) begin
          done = 1'b1;
          nxt  = bnephp_pkg::FIELD_MCAST_HI;
        end
      end
      bnephp_pkg::FIELD_MCAST_HI: begin
        if (ctx.field_position >= bnephp_pkg::MAC_LAST) begin
          n.list_bytes_left = mcast_left;
          done = 1'b1;
          nxt  = (mcast_left != 16'd0) ? bnephp_pkg::FIELD_MCAST_LO : after_msg;
        end
      end
      bnephp_pkg::FIELD_EXT_HDR: begin
        n.extension_pending = packet_byte[bnephp_pkg::EXT_BIT];
        n.ext_control       = (kind == bnephp_pkg::EXT_CONTROL);
        n.in_extension      = 1'b1;
        done = 1'b1;
        nxt  = bnephp_pkg::FIELD_EXT_LEN;
      end
      bnephp_pkg::FIELD_EXT_LEN: begin
        n.list_bytes_left = {8'd0, packet_byte};
        done = 1'b1;
        if (ctx.ext_control) begin
          nxt = bnephp_pkg::FIELD_CTRL_TYPE;
        end else begin
          nxt = (packet_byte == 8'd0) ? after_msg : bnephp_pkg::FIELD_EXT_SKIP;
        end
      end
      bnephp_pkg::FIELD_EXT_SKIP: begin
        n.list_bytes_left = skip_left;
        if (skip_left == 16'd0) begin
          done = 1'b1;
          nxt  = after_msg;
        end
      end
      bnephp_pkg::FIELD_PAYLOAD: begin
        done = 1'b0;
      end
      default: begin
        cur  = bnephp_pkg::FIELD_PAYLOAD;
        done = 1'b1;
        nxt  = bnephp_pkg::FIELD_PAYLOAD;
      end
    endcase

    if (done) begin
      n.parse_state       = nxt;
      n.field_position    = 16'd0;
      n.value_accumulator = 16'd0;
    end else begin
      n.field_position    = (ctx.field_position == bnephp_pkg::POS_MAX)
                            ? ctx.field_position : pos_plus[15:0];
      n.value_accumulator = val;
    end

    result.byte_out             = packet_byte;
    result.field_code           = cur;
    result.byte_in_field        = ctx.field_position;
    result.field_value          = val;
    result.packet_kind          = n.saved_kind;
    result.has_extension        = n.top_extension;
    result.ether_type           = n.saved_ether_type;
    result.group_source_warning = n.source_group_flag;
    result.header_truncated     = end_of_packet && (n.parse_state != bnephp_pkg::FIELD_PAYLOAD);
    result.last_byte            = end_of_packet;

    ctx_next = end_of_packet ? bnephp_pkg::CTX_RESET : n;
  end

endmodule

// File: design/bnep_header_parser_core.sv
// top level of the bnep header parser: input register, parse step, result register
//
// usage: bytes of a bnep packet enter on packet_byte with end_of_packet high on
// the last byte, one transfer per byte under in_valid / in_stall. each byte
// leaves as one result transfer under out_valid / out_stall, tagged with its
// header field, its place in that field and the running big-endian value, along
// with packet kind, extension bit, captured ethertype and the two warnings.
// a result is registered once its byte has passed the input register and the
// parse step; throughput is one byte per cycle while the receiver does not
// stall. the parse step is a single pass of combinational logic between the
// input register and the result register, and it sets that rate.
// when the receiver stalls, the result register holds, then the input register
// fills and in_stall rises until the result is taken. an item's result and the
// next input transfer may happen in the same cycle.
// reset empties both registers and returns the parser to the type byte; the
// parser also returns there after every byte marked end_of_packet.
`timescale 1ns / 1ps

module bnep_header_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  packet_byte,
  input  logic        end_of_packet,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  byte_out,
  output logic [4:0]  field_code,
  output logic [15:0] byte_in_field,
  output logic [15:0] field_value,
  output logic [6:0]  packet_kind,
  output logic        has_extension,
  output logic [15:0] ether_type,
  output logic        group_source_warning,
  output logic        header_truncated,
  output logic        last_byte
);

  logic                      in_full;
  logic [7:0]                in_byte;
  logic                      in_eop;
  logic                      out_blocked;
  logic                      advance;
  bnephp_pkg::parse_ctx_t    ctx;
  bnephp_pkg::parse_ctx_t    ctx_next;
  bnephp_pkg::tag_result_t   step_result;
  bnephp_pkg::tag_result_t   result;

  assign out_blocked = out_valid && out_stall;
  assign advance     = in_full && !out_blocked;
  assign in_stall    = in_full && out_blocked;

  bnephp_step u_step (
    .ctx           (ctx),
    .packet_byte   (in_byte),
    .end_of_packet (in_eop),
    .ctx_next      (ctx_next),
    .result        (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      ctx       <= bnephp_pkg::CTX_RESET;
    end else begin
      if (in_valid && !in_stall) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        ctx       <= ctx_next;
      end else if (!out_blocked) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= packet_byte;
      in_eop  <= end_of_packet;
    end
    if (advance) begin
      result <= step_result;
    end
  end

  assign byte_out             = result.byte_out;
  assign field_code           = result.field_code;
  assign byte_in_field        = result.byte_in_field;
  assign field_value          = result.field_value;
  assign packet_kind          = result.packet_kind;
  assign has_extension        = result.has_extension;
  assign ether_type           = result.ether_type;
  assign group_source_warning = result.group_source_warning;
  assign header_truncated     = result.header_truncated;
  assign last_byte            = result.last_byte;

  a_trunc_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && header_truncated |-> last_byte)
    else $error("truncation flag on a byte that is not the last");

  a_clear_after_eop: assert property (@(posedge clk) disable iff (rst)
    advance && in_eop |=> ctx.parse_state == bnephp_pkg::FIELD_TYPE
                          && ctx.field_position == 16'd0 && !ctx.extension_pending)
    else $error("parser not cleared after last byte");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full && out_valid)
    else $error("input stalled with room to spare");

  a_type_pos_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && field_code == bnephp_pkg::FIELD_TYPE |-> byte_in_field == 16'd0)
    else $error("type byte tagged at nonzero position");

  a_result_follows_transfer: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("parsed byte produced no result");

endmodule
